[rtl/msc_pkg.sv]
`default_nettype none
package msc_pkg;

  localparam int SETS    = 256;
  localparam int WAYS    = 4;
  localparam int SET_W   = $clog2(SETS);
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int REC_W   = WAY_W;
  localparam int BOUND_W = $clog2(WAYS + 1);
  localparam int TAG_W   = 31;
  localparam int MESI_W  = 2;
  localparam int ENTRY_W = TAG_W + MESI_W + REC_W;
  localparam int ROW_W   = WAYS * ENTRY_W;
  localparam int CNT_W   = 32;
  localparam int ADDR_W  = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 4;

  localparam logic [MESI_W-1:0] ST_I = 2'd0;
  localparam logic [MESI_W-1:0] ST_S = 2'd1;
  localparam logic [MESI_W-1:0] ST_E = 2'd2;
  localparam logic [MESI_W-1:0] ST_M = 2'd3;

  localparam logic [1:0] FUNC_ACCESS = 2'd0;
  localparam logic [1:0] FUNC_SNOOP  = 2'd1;
  localparam logic [1:0] FUNC_FILL   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd1;

  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] address;
    logic              is_write;
    logic              bus_exclusive;
    logic              shared_elsewhere;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic              bus_needed;
    logic              bus_request_exclusive;
    logic [ADDR_W-1:0] block_address;
    logic              writeback_needed;
    logic              invalidated;
    logic [CNT_W-1:0]  miss_total;
    logic [CNT_W-1:0]  access_total;
    logic [CNT_W-1:0]  eviction_total;
    logic [CNT_W-1:0]  writeback_total;
  } out_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

[rtl/mesi_set_assoc_cache_controller_unit.sv]
`default_nettype none
// MESI tag/state controller for one set-associative L1 (256 sets x 4 ways, LRU).
// Each transaction (core access, snoop or bus fill) first reads the set's row
// of tags, states and recency from the tag RAM, then updates and writes it
// back and loads the result register, waiting while a stalled output holds
// that register. A new one is taken once the last is done. No clearing pass:
// per-set valid flops make untouched sets read as all invalid right after reset.
// Config writes (set_bits, offset_bits) are accepted whenever out of reset; do
// them when idle.
module mesi_set_assoc_cache_controller_unit import msc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_t                      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = !rst;

  msc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  msc_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
`default_nettype wire

[rtl/msc_ram.sv]
`default_nettype none
module msc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/msc_ctrl.sv]
`default_nettype none
module msc_ctrl import msc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    in_ready    = (state == S_IDLE) && !rst;
    cmd.capture = in_valid && (state == S_IDLE) && !rst;
    cmd.exec    = (state == S_EXEC) && !status.out_busy;
    state_next  = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!status.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

[rtl/msc_dpath.sv]
`default_nettype none
module msc_dpath import msc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cmd_t                 cmd,
  output status_t                   status,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_t                      out_data,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  logic [3:0] set_bits;
  logic [3:0] offset_bits;
  in_t        in_q;
  logic       row_ok;
  logic [SETS-1:0] row_vld;
  logic [SET_W-1:0] set_q;
  logic [CNT_W-1:0] misses, accesses, evictions, writebacks;

  logic [ADDR_W-1:0] set_full;
  logic [SET_W-1:0]  set_idx;
  logic [ROW_W-1:0]  rdata;
  logic [ROW_W-1:0]  wdata;

  always_comb begin
    set_full = (in_data.address >> offset_bits) & ((ADDR_W'(1) << set_bits) - ADDR_W'(1));
    set_idx  = set_full[SET_W-1:0];
  end

  msc_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
    .clk   (clk),
    .we    (cmd.exec),
    .waddr (set_q),
    .wdata (wdata),
    .re    (cmd.capture),
    .raddr (set_idx),
    .rdata (rdata)
  );

  logic [TAG_W-1:0]  tg   [WAYS];
  logic [MESI_W-1:0] ms   [WAYS];
  logic [REC_W-1:0]  rc   [WAYS];
  logic [TAG_W-1:0]  ntg  [WAYS];
  logic [MESI_W-1:0] nms  [WAYS];
  logic [REC_W-1:0]  nrc  [WAYS];
  logic [TAG_W-1:0]  tag;
  logic [ADDR_W-1:0] tag_full;
  logic [4:0]        tag_sh;
  logic              hit_found, vic_inv;
  logic [WAY_W-1:0]  hw, vw, tw;
  logic [REC_W-1:0]  best, dr;
  logic [BOUND_W-1:0] bound;
  logic              do_touch, do_drop;
  logic [MESI_W-1:0] ns;
  logic              r_hit, r_nbus, r_bexc, r_nwb, r_inv;
  logic              inc_m, inc_a, inc_e, inc_w;
  logic [CNT_W-1:0]  m_next, a_next, e_next, w_next;

  always_comb begin
    tag_sh   = {1'b0, offset_bits} + {1'b0, set_bits};
    tag_full = in_q.address >> tag_sh;
    tag      = tag_full[TAG_W-1:0];
    for (int w = 0; w < WAYS; w++) begin
      if (row_ok) begin
        tg[w] = rdata[w*ENTRY_W+REC_W+MESI_W +: TAG_W];
        ms[w] = rdata[w*ENTRY_W+REC_W +: MESI_W];
        rc[w] = rdata[w*ENTRY_W +: REC_W];
      end else begin
        tg[w] = '0;
        ms[w] = ST_I;
        rc[w] = '0;
      end
    end
    hit_found = 1'b0;
    hw        = '0;
    vic_inv   = 1'b0;
    vw        = '0;
    best      = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_found && ms[w] != ST_I && tg[w] == tag) begin
        hit_found = 1'b1;
        hw        = WAY_W'(w);
      end
      if (!vic_inv) begin
        if (ms[w] == ST_I) begin
          vic_inv = 1'b1;
          vw      = WAY_W'(w);
        end else if (w == 0 || rc[w] > best) begin
          best = rc[w];
          vw   = WAY_W'(w);
        end
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      ntg[w] = tg[w];
      nms[w] = ms[w];
      nrc[w] = rc[w];
    end
    r_hit = 1'b0; r_nbus = 1'b0; r_bexc = 1'b0; r_nwb = 1'b0; r_inv = 1'b0;
    inc_m = 1'b0; inc_a = 1'b0; inc_e = 1'b0; inc_w = 1'b0;
    do_touch = 1'b0; do_drop = 1'b0;
    tw    = hw;
    bound = {1'b0, rc[hw]};
    dr    = rc[hw];
    ns    = in_q.bus_exclusive ? ST_M : (in_q.shared_elsewhere ? ST_S : ST_E);
    unique case (in_q.func)
      FUNC_ACCESS: begin
        inc_a = 1'b1;
        if (hit_found) begin
          r_hit    = 1'b1;
          do_touch = 1'b1;
          if (in_q.is_write) begin
            if (ms[hw] == ST_E) begin
              nms[hw] = ST_M;
            end else if (ms[hw] == ST_S) begin
              r_nbus = 1'b1;
              r_bexc = 1'b1;
            end
          end
        end else begin
          inc_m  = 1'b1;
          r_nbus = 1'b1;
          r_bexc = in_q.is_write;
          if (ms[vw] != ST_I) begin
            inc_e = 1'b1;
            if (ms[vw] == ST_M) begin
              inc_w = 1'b1;
              r_nwb = 1'b1;
            end
          end
        end
      end
      FUNC_SNOOP: begin
        if (hit_found) begin
          if (ms[hw] == ST_M) begin
            inc_w = 1'b1;
          end
          if (!in_q.bus_exclusive) begin
            if (ms[hw] == ST_M || ms[hw] == ST_E) begin
              nms[hw] = ST_S;
            end
          end else begin
            do_drop = 1'b1;
            r_inv   = 1'b1;
          end
        end
      end
      FUNC_FILL: begin
        do_touch = 1'b1;
        if (hit_found) begin
          nms[hw] = ns;
        end else begin
          tw    = vw;
          bound = BOUND_W'(WAYS);
          if (ms[vw] != ST_I) begin
            bound = {1'b0, rc[vw]};
            inc_e = 1'b1;
            if (ms[vw] == ST_M) begin
              inc_w = 1'b1;
            end
          end
          ntg[vw] = tag;
          nms[vw] = ns;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < WAYS; i++) begin
      if (do_touch) begin
        if (WAY_W'(i) == tw) begin
          nrc[i] = '0;
        end else if (ms[i] != ST_I && {1'b0, rc[i]} < bound) begin
          nrc[i] = rc[i] + REC_W'(1);
        end
      end
      if (do_drop) begin
        if (WAY_W'(i) == hw) begin
          nms[i] = ST_I;
          nrc[i] = '0;
        end else if (ms[i] != ST_I && rc[i] > dr) begin
          nrc[i] = rc[i] - REC_W'(1);
        end
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      wdata[w*ENTRY_W +: ENTRY_W] = {ntg[w], nms[w], nrc[w]};
    end
    m_next = (inc_m && misses     != '1) ? misses     + CNT_W'(1) : misses;
    a_next = (inc_a && accesses   != '1) ? accesses   + CNT_W'(1) : accesses;
    e_next = (inc_e && evictions  != '1) ? evictions  + CNT_W'(1) : evictions;
    w_next = (inc_w && writebacks != '1) ? writebacks + CNT_W'(1) : writebacks;
    status.out_busy = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= 4'd6;
      offset_bits <= 4'd6;
      row_vld     <= '0;
      misses      <= '0;
      accesses    <= '0;
      evictions   <= '0;
      writebacks  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SET_BITS:    set_bits    <= cfg_data;
          REG_OFFSET_BITS: offset_bits <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.exec) begin
        row_vld[set_q] <= 1'b1;
        misses         <= m_next;
        accesses       <= a_next;
        evictions      <= e_next;
        writebacks     <= w_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_q   <= in_data;
      set_q  <= set_idx;
      row_ok <= row_vld[set_idx];
    end
    if (cmd.exec) begin
      out_data.hit                   <= r_hit;
      out_data.bus_needed            <= r_nbus;
      out_data.bus_request_exclusive <= r_bexc;
      out_data.block_address         <= in_q.address & ~((ADDR_W'(1) << offset_bits) - ADDR_W'(1));
      out_data.writeback_needed      <= r_nwb;
      out_data.invalidated           <= r_inv;
      out_data.miss_total            <= m_next;
      out_data.access_total          <= a_next;
      out_data.eviction_total        <= e_next;
      out_data.writeback_total       <= w_next;
    end
  end

endmodule
`default_nettype wire
